[rtl/bnc_pkg.sv]
// Shared types and constants for the 3x3 binary grid neighbor counter.
// No dependencies; used by the front, queue, back and top level files.
`timescale 1ns / 1ps

package bnc_pkg;

  // Largest supported grid edge, the position and size widths that follow from it, and the count width.
  localparam int MAX_SIZE = 64;
  localparam int POS_W    = 6;
  localparam int GRID_W   = 7;
  localparam int CNT_W    = 4;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_GRID_SIZE = 1'b0;
  localparam logic [GRID_W-1:0] GRID_RESET = 7'd8;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Result slots of one item, in the order they are delivered.
  localparam int SLOT_UP_FULL  = 0;  // cell above and to the left
  localparam int SLOT_UP_EDGE  = 1;  // cell above, right edge
  localparam int SLOT_LO_FULL  = 2;  // cell to the left, bottom row
  localparam int SLOT_LO_EDGE  = 3;  // this cell, bottom right corner

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [3:0]       mask;
    logic [CNT_W-1:0] up_full;
    logic [CNT_W-1:0] up_edge;
    logic [CNT_W-1:0] lo_full;
    logic [CNT_W-1:0] lo_edge;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/binary_grid_neighbor_count_3x3.sv]
// The first result beat of a cell is registered in a queue slot and then in the output stage.
// Throughput: one cell per cycle is accepted while the four-entry queue has room;
// results leave at one beat per cycle, and the output port sets the sustained rate.
// A cell yields zero to four beats, so a grid of N x N cells takes N*N result beats.
// Reset clears position, windows, queue and output valid and sets grid_size to 8;
// the line buffers are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module binary_grid_neighbor_count_3x3 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration port. Only grid_size exists, at byte address zero.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bnc_pkg::APB_AW-1:0] paddr,
  input  logic [bnc_pkg::APB_DW-1:0] pwdata,
  output logic [bnc_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  // Cell input channel, one cell per beat in raster order.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mine_i,
  // Result channel, one completed cell per beat.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bnc_pkg::POS_W-1:0]  cell_row_o,
  output logic [bnc_pkg::POS_W-1:0]  cell_col_o,
  output logic [bnc_pkg::CNT_W-1:0]  count_o,
  output logic                       last_of_run_o
);
  import bnc_pkg::*;

  logic              cfg_we;
  logic [GRID_W-1:0] grid_size;
  logic              push, pop;
  entry_t            push_entry, head;
  q_stat_t           q_stat;

  // The port never waits. A write lands on the access cycle; the word index
  // is the address bit above the byte offset, so only index zero is decoded.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_GRID_SIZE);
  assign prdata = (paddr[2] == REG_GRID_SIZE) ? APB_DW'(grid_size) : '0;

  // The front end owns the line buffers and the partial column sums. For
  // each accepted cell it works out every neighbor count that the cell
  // completes and queues them as one entry; cells that complete nothing
  // are dropped here.
  bnc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mine_i       (mine_i),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata[GRID_W-1:0]),
    .grid_size_o  (grid_size),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // The queue absorbs the burst of up to four beats that a cell on the right
  // edge or bottom row produces, so the input keeps flowing meanwhile.
  bnc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (q_stat)
  );

  // The back end sends the results of one entry in raster order and flags
  // the final beat of each entry with last_of_run.
  bnc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_row_o    (cell_row_o),
    .cell_col_o    (cell_col_o),
    .count_o       (count_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[rtl/bnc_front.sv]
// Front end: accepts grid cells, keeps the line buffers and column windows,
// and classifies each cell into a queue entry. Depends on bnc_pkg.
`timescale 1ns / 1ps

module bnc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mine_i,
  input  logic                     cfg_we_i,
  input  logic [bnc_pkg::GRID_W-1:0] cfg_wdata_i,
  output logic [bnc_pkg::GRID_W-1:0] grid_size_o,
  input  bnc_pkg::q_stat_t         q_stat_i,
  output logic                     push_o,
  output bnc_pkg::entry_t          push_entry_o
);
  import bnc_pkg::*;

  localparam logic [GRID_W-1:0] GRID_MAX = GRID_W'(MAX_SIZE);
  localparam logic [POS_W-1:0]  LAST_MAX = POS_W'(MAX_SIZE - 1);

  logic [GRID_W-1:0] grid_q, grid_d;
  logic [POS_W-1:0]  row_q, row_d, col_q, col_d;
  logic [1:0]        cw_q [3];
  logic [1:0]        cw_d [3];
  logic [1:0]        lw_q [3];
  logic [1:0]        lw_d [3];

  // Each line buffer entry holds {row r-2, row r-1} for one column.
  logic [1:0]        line_mem [MAX_SIZE];
  logic [1:0]        pre_q;
  logic [1:0]        wr_data;
  logic              accept;
  logic [POS_W-1:0]  last;
  logic              ob, rb;
  logic              c0, c_last, r_last;
  entry_t            ent;

  always_comb begin
    if (grid_q == '0) begin
      last = '0;
    end else if (grid_q > GRID_MAX) begin
      last = LAST_MAX;
    end else begin
      last = POS_W'(grid_q - GRID_W'(1));
    end
  end

  assign accept     = in_valid_i & ~q_stat_i.full;
  assign in_stall_o = q_stat_i.full;
  assign ob         = (row_q >= POS_W'(2)) & pre_q[1];
  assign rb         = (row_q >= POS_W'(1)) & pre_q[0];
  assign c0         = (col_q == '0);
  assign c_last     = (col_q >= last);
  assign r_last     = (row_q >= last);
  assign wr_data    = {pre_q[0], mine_i};

  always_comb begin
    grid_d = grid_q;
    row_d  = row_q;
    col_d  = col_q;
    cw_d   = cw_q;
    lw_d   = lw_q;
    if (cfg_we_i) begin
      grid_d = cfg_wdata_i;
      row_d  = '0;
      col_d  = '0;
      cw_d   = '{default: '0};
      lw_d   = '{default: '0};
    end else if (accept) begin
      cw_d[0] = c0 ? 2'd0 : cw_q[1];
      cw_d[1] = c0 ? 2'd0 : cw_q[2];
      cw_d[2] = 2'({1'b0, ob} + {1'b0, rb} + {1'b0, mine_i});
      lw_d[0] = c0 ? 2'd0 : lw_q[1];
      lw_d[1] = c0 ? 2'd0 : lw_q[2];
      lw_d[2] = 2'({1'b0, rb} + {1'b0, mine_i});
      if (c_last) begin
        col_d = '0;
        row_d = r_last ? '0 : row_q + POS_W'(1);
      end else begin
        col_d = col_q + POS_W'(1);
      end
    end
  end

  always_comb begin
    ent.row     = row_q;
    ent.col     = col_q;
    ent.up_full = CNT_W'(cw_d[0]) + CNT_W'(cw_d[1]) + CNT_W'(cw_d[2]);
    ent.up_edge = CNT_W'(cw_d[1]) + CNT_W'(cw_d[2]);
    ent.lo_full = CNT_W'(lw_d[0]) + CNT_W'(lw_d[1]) + CNT_W'(lw_d[2]);
    ent.lo_edge = CNT_W'(lw_d[1]) + CNT_W'(lw_d[2]);
    ent.mask[SLOT_UP_FULL] = (row_q != '0) & ~c0;
    ent.mask[SLOT_UP_EDGE] = (row_q != '0) & (col_q == last);
    ent.mask[SLOT_LO_FULL] = (row_q == last) & ~c0;
    ent.mask[SLOT_LO_EDGE] = (row_q == last) & (col_q == last);
  end

  assign push_o       = accept & (ent.mask != '0);
  assign push_entry_o = ent;
  assign grid_size_o  = grid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
      row_q  <= '0;
      col_q  <= '0;
      cw_q   <= '{default: '0};
      lw_q   <= '{default: '0};
    end else begin
      grid_q <= grid_d;
      row_q  <= row_d;
      col_q  <= col_d;
      cw_q   <= cw_d;
      lw_q   <= lw_d;
    end
  end

  // Line buffer: written at the current column, and the entry for the next
  // column is read ahead, with a bypass when both addresses match.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col_q] <= wr_data;
    end
    if (accept && (col_d == col_q)) begin
      pre_q <= wr_data;
    end else begin
      pre_q <= line_mem[col_d];
    end
  end

endmodule

[rtl/bnc_queue.sv]
// Short entry queue that decouples classification from result delivery.
// Depends on bnc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module bnc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bnc_pkg::entry_t  push_entry_i,
  input  logic             pop_i,
  output bnc_pkg::entry_t  head_o,
  output bnc_pkg::q_stat_t stat_o
);
  import bnc_pkg::*;

  localparam logic [QPTR_W:0] CNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

  entry_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign head_o       = slot_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QPTR_W + 1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

[rtl/bnc_back.sv]
// Back end: expands each queue entry into its result beats, one per cycle while
// the output is not stalled, through a registered output stage. Depends on bnc_pkg.
`timescale 1ns / 1ps

module bnc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bnc_pkg::entry_t           head_i,
  input  bnc_pkg::q_stat_t          q_stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bnc_pkg::POS_W-1:0] cell_row_o,
  output logic [bnc_pkg::POS_W-1:0] cell_col_o,
  output logic [bnc_pkg::CNT_W-1:0] count_o,
  output logic                      last_of_run_o
);
  import bnc_pkg::*;

  entry_t           ent_q, ent_d, src;
  logic [3:0]       rem_q, rem_d, mask, rest;
  logic             have, load;
  logic             ovalid_q, ovalid_d;
  logic [POS_W-1:0] orow_q, orow_d, ocol_q, ocol_d;
  logic [CNT_W-1:0] ocnt_q, ocnt_d;
  logic             olast_q, olast_d;

  assign load = ~ovalid_q | ~out_stall_i;

  always_comb begin
    src   = (rem_q != '0) ? ent_q : head_i;
    mask  = (rem_q != '0) ? rem_q : head_i.mask;
    have  = (rem_q != '0) | ~q_stat_i.empty;
    pop_o = load & (rem_q == '0) & ~q_stat_i.empty;

    orow_d = orow_q;
    ocol_d = ocol_q;
    ocnt_d = ocnt_q;
    rest   = mask;
    if (mask[SLOT_UP_FULL]) begin
      orow_d = src.row - POS_W'(1);
      ocol_d = src.col - POS_W'(1);
      ocnt_d = src.up_full;
      rest[SLOT_UP_FULL] = 1'b0;
    end else if (mask[SLOT_UP_EDGE]) begin
      orow_d = src.row - POS_W'(1);
      ocol_d = src.col;
      ocnt_d = src.up_edge;
      rest[SLOT_UP_EDGE] = 1'b0;
    end else if (mask[SLOT_LO_FULL]) begin
      orow_d = src.row;
      ocol_d = src.col - POS_W'(1);
      ocnt_d = src.lo_full;
      rest[SLOT_LO_FULL] = 1'b0;
    end else begin
      orow_d = src.row;
      ocol_d = src.col;
      ocnt_d = src.lo_edge;
      rest[SLOT_LO_EDGE] = 1'b0;
    end
    olast_d = (rest == '0);

    ent_d    = ent_q;
    rem_d    = rem_q;
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = have;
      if (have) begin
        rem_d = rest;
        ent_d = src;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      rem_q    <= rem_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (load && have) begin
      orow_q  <= orow_d;
      ocol_q  <= ocol_d;
      ocnt_q  <= ocnt_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign cell_row_o    = orow_q;
  assign cell_col_o    = ocol_q;
  assign count_o       = ocnt_q;
  assign last_of_run_o = olast_q;

endmodule

[bench/binary_grid_neighbor_count_3x3_test.sv]
// Self-checking bench for the streaming 3x3 neighbor counter over a binary grid.
// Depends only on bnc_pkg and the binary_grid_neighbor_count_3x3 RTL.
`timescale 1ns / 1ps

module binary_grid_neighbor_count_3x3_test;

  import bnc_pkg::*;

  // Run limits. The cycle cap is far above the slowest legal run: about a hundred
  // and fifty cells, each with up to four result beats behind random receiver stalls.
  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int SMALL_BUDGET  = 24;
  localparam int IDLE_PERCENT  = 32;
  localparam int HOLD_AFTER    = 18;
  localparam int HOLD_CYCLES   = 80;

  // grid_size is register zero, so it sits at byte address zero.
  localparam logic [APB_AW-1:0] GRID_ADDR = APB_AW'(4 * REG_GRID_SIZE);

  // One result beat as seen on the output port.
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [CNT_W-1:0] count;
    logic             last_of_run;
  } neighbor_tally_t;

  // The directed part is a table of register accesses and cells.
  typedef enum logic [1:0] {
    DO_WRITE,
    DO_READ,
    DO_CELL
  } plan_op_e;

  typedef struct packed {
    plan_op_e          op;
    logic [GRID_W-1:0] arg;    // size to write, value to read back, or cell bit
    logic              typed;  // expectation typed in below instead of predicted
    logic [CNT_W-1:0]  want;   // typed count of a one-cell grid
  } plan_row_t;

  localparam int PLAN_LEN = 27;

  // Rows with typed set carry an expectation that needs no predictor: the
  // register after reset, its read back, and one-cell grids where the count is
  // just the cell itself. Size 0 must behave as a one-cell grid. The 2x2 grid
  // has its last cell complete four cells at once; the all-ones 3x3 grid gives
  // the maximum count of nine in its center; the two cells after it leave a
  // grid partly done, so the following write has to restart it.
  plan_row_t plan [PLAN_LEN] = '{
    '{DO_READ,  7'd8,   1'b1, 4'd0},
    '{DO_WRITE, 7'd1,   1'b0, 4'd0},
    '{DO_READ,  7'd1,   1'b1, 4'd0},
    '{DO_CELL,  7'd1,   1'b1, 4'd1},
    '{DO_CELL,  7'd0,   1'b1, 4'd0},
    '{DO_WRITE, 7'd0,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b1, 4'd1},
    '{DO_CELL,  7'd0,   1'b1, 4'd0},
    '{DO_WRITE, 7'd2,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd0,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_WRITE, 7'd3,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_CELL,  7'd0,   1'b0, 4'd0},
    '{DO_CELL,  7'd1,   1'b0, 4'd0},
    '{DO_WRITE, 7'd127, 1'b0, 4'd0},
    '{DO_READ,  7'd127, 1'b1, 4'd0}
  };

  // Block ports. Every input starts at a known value.
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              mine_i      = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b1;
  logic [POS_W-1:0]  cell_row_o;
  logic [POS_W-1:0]  cell_col_o;
  logic [CNT_W-1:0]  count_o;
  logic              last_of_run_o;

  binary_grid_neighbor_count_3x3 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mine_i        (mine_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_row_o    (cell_row_o),
    .cell_col_o    (cell_col_o),
    .count_o       (count_o),
    .last_of_run_o (last_of_run_o)
  );

  // Mirror of the block: register, line buffers, raster position and the two
  // column-sum windows (three rows for cells above, two rows for the bottom row).
  logic [GRID_W-1:0] size_reg = GRID_RESET;
  logic              older_line  [MAX_SIZE];
  logic              recent_line [MAX_SIZE];
  int unsigned       at_row;
  int unsigned       at_col;
  int unsigned       three_row_sum [3];
  int unsigned       two_row_sum   [3];

  neighbor_tally_t   new_tallies [$];  // cells completed by the latest beat
  neighbor_tally_t   due_tallies [$];  // result beats still to arrive, oldest first

  int unsigned       errors       = 0;
  int unsigned       cycles       = 0;
  int unsigned       cells_sent   = 0;
  int unsigned       tallies_seen = 0;
  int unsigned       size_writes  = 0;
  int unsigned       stall_seen   = 0;
  logic              calm_phase   = 1'b0;  // no random idling on either side while set

  // Grid edge as the block uses it: 0 acts as 1, anything above MAX_SIZE as MAX_SIZE.
  function automatic int unsigned grid_side();
    int unsigned n;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > MAX_SIZE) n = MAX_SIZE;
    return n;
  endfunction

  function automatic void add_tally(input int unsigned r, input int unsigned c,
                                    input int unsigned sum);
    neighbor_tally_t t;
    t.row         = POS_W'(r);
    t.col         = POS_W'(c);
    t.count       = CNT_W'(sum);
    t.last_of_run = 1'b0;
    new_tallies.push_back(t);
  endfunction

  // Takes one cell and fills new_tallies with the cells it completes, in raster
  // order: above-left, above at the right edge, left in the bottom row, and
  // the cell itself in the bottom right corner.
  function automatic void advance_box_sum(input logic b);
    int unsigned n;
    int unsigned r;
    int unsigned c;
    int unsigned above2;
    int unsigned above1;
    int unsigned lastpos;
    n       = grid_side();
    r       = at_row;
    c       = at_col;
    lastpos = n - 1;
    new_tallies.delete();
    // Rows above the grid read as zero, whatever the line buffers hold.
    above2 = (r >= 2) ? int'(older_line[c])  : 0;
    above1 = (r >= 1) ? int'(recent_line[c]) : 0;
    older_line[c]  = recent_line[c];
    recent_line[c] = b;
    if (c == 0) begin
      three_row_sum = '{0, 0, 0};
      two_row_sum   = '{0, 0, 0};
    end
    three_row_sum[0] = three_row_sum[1];
    three_row_sum[1] = three_row_sum[2];
    three_row_sum[2] = above2 + above1 + b;
    two_row_sum[0]   = two_row_sum[1];
    two_row_sum[1]   = two_row_sum[2];
    two_row_sum[2]   = above1 + b;
    if (r >= 1 && c >= 1)
      add_tally(r - 1, c - 1, three_row_sum[0] + three_row_sum[1] + three_row_sum[2]);
    if (r >= 1 && c == lastpos)
      add_tally(r - 1, c, three_row_sum[1] + three_row_sum[2]);
    if (r == lastpos && c >= 1)
      add_tally(r, c - 1, two_row_sum[0] + two_row_sum[1] + two_row_sum[2]);
    if (r == lastpos && c == lastpos)
      add_tally(r, c, two_row_sum[1] + two_row_sum[2]);
    if (new_tallies.size() > 0)
      new_tallies[new_tallies.size() - 1].last_of_run = 1'b1;
    // Raster advance; the end of the grid wraps to the top left.
    if (c >= lastpos) begin
      at_col = 0;
      at_row = (r >= lastpos) ? 0 : r + 1;
    end else begin
      at_col = c + 1;
    end
  endfunction

  function automatic bit field_ok(input string name, input int unsigned want,
                                  input logic [7:0] got);
    if (got !== 8'(want)) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // 100 MHz clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a run that is still going at the cap has hung.
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("binary_grid_neighbor_count_3x3_test failed");
    $finish;
  end

  // Result side. Each beat taken at an edge is checked against the oldest
  // expectation. Stall is chosen at random, except for one long hold-off that
  // lets the block's queue fill and push back on the cell input. The directed
  // table yields seventeen beats, so the hold-off starts once the wide grid's
  // second row has begun to produce results.
  initial begin
    neighbor_tally_t got;
    neighbor_tally_t want;
    int unsigned     hold_left;
    bit              hold_done;
    bit              ok;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.row         = cell_row_o;
        got.col         = cell_col_o;
        got.count       = count_o;
        got.last_of_run = last_of_run_o;
        tallies_seen++;
        if (due_tallies.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual row %0d col %0d count %0d",
                   $realtime, got.row, got.col, got.count);
          errors++;
        end else begin
          want = due_tallies.pop_front();
          ok = field_ok("cell_row", want.row, 8'(got.row));
          ok = field_ok("cell_col", want.col, 8'(got.col)) && ok;
          ok = field_ok("count", want.count, 8'(got.count)) && ok;
          ok = field_ok("last_of_run", want.last_of_run, 8'(got.last_of_run)) && ok;
          if (!ok) errors++;
        end
      end
      if (rst_ni && in_valid_i && in_stall_o) stall_seen++;
      if (!hold_done && tallies_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm_phase && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Offers one cell, with a random gap first, and records what it completes once
  // the block takes it. A typed cell pushes its written-in result instead of the
  // prediction, but the mirror is advanced either way.
  task automatic offer_cell(input logic b, input logic typed, input logic [CNT_W-1:0] want);
    neighbor_tally_t t;
    while (!calm_phase && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mine_i     <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cells_sent++;
    advance_box_sum(b);
    if (typed) begin
      t.row         = '0;
      t.col         = '0;
      t.count       = want;
      t.last_of_run = 1'b1;
      due_tallies.push_back(t);
    end else begin
      foreach (new_tallies[k]) due_tallies.push_back(new_tallies[k]);
    end
  endtask

  // Brings the block to rest: input idle, all results in, then a settling wait.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_tallies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup then access; the register takes the value at the access edge and the
  // block starts a fresh grid, so the mirror does the same.
  task automatic reg_write(input logic [GRID_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GRID_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_reg = value;
    at_row   = 0;
    at_col   = 0;
    three_row_sum = '{0, 0, 0};
    two_row_sum   = '{0, 0, 0};
    size_writes++;
  endtask

  task automatic check_size_readback(input logic [GRID_W-1:0] want);
    logic [APB_DW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= GRID_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DW'(want)) begin
      $display("%0t: grid_size read back, expected %0d, actual %0d", $realtime, want, got);
      errors++;
    end
  endtask

  // Stimulus: directed table, one wide partial grid, then random grids, mostly small.
  initial begin
    int unsigned      side;
    int unsigned      cells;
    int unsigned      density;
    int unsigned      pick;
    int unsigned      small_cells;
    logic [GRID_W-1:0] size_val;
    logic             b;

    foreach (older_line[k]) begin
      older_line[k]  = 1'b0;
      recent_line[k] = 1'b0;
    end
    at_row = 0;
    at_col = 0;
    three_row_sum = '{0, 0, 0};
    two_row_sum   = '{0, 0, 0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register accesses wait for the block to be idle first.
    for (int i = 0; i < PLAN_LEN; i++) begin
      case (plan[i].op)
        DO_WRITE: begin
          drain();
          reg_write(plan[i].arg);
        end
        DO_READ: begin
          drain();
          check_size_readback(plan[i].arg);
        end
        default: begin
          offer_cell(plan[i].arg[0], plan[i].typed, plan[i].want);
        end
      endcase
    end

    // The table leaves grid_size at 127, which acts as the full 64 columns.
    // A whole first row and the start of the second go in with no idling on
    // either side; the receiver's long hold-off falls in the second row and
    // backs the queue up into the input.
    calm_phase = 1'b1;
    for (int i = 0; i < MAX_SIZE + 12; i++)
      offer_cell(1'($urandom_range(1)), 1'b0, '0);
    calm_phase = 1'b0;
    drain();
    reg_write(7'(MAX_SIZE));
    check_size_readback(7'(MAX_SIZE));

    // Random phases. Most are whole small grids with random fill; some end in
    // the middle of a grid so the next size write has to restart it, and a few
    // pick an out-of-range or wide size for a short stretch of the top row.
    small_cells = 0;
    while (small_cells < SMALL_BUDGET) begin
      drain();
      pick = $urandom_range(7);
      if (pick == 0) size_val = 7'd0;
      else if (pick == 1) size_val = 7'd1;
      else if (pick == 7) size_val = 7'($urandom_range(MAX_SIZE, 127));
      else size_val = 7'($urandom_range(2, 8));
      reg_write(size_val);
      check_size_readback(size_val);
      side = grid_side();
      if (side > 8) begin
        cells = $urandom_range(5, 20);
      end else begin
        cells = side * side;
        if (side > 1 && $urandom_range(3) == 0)
          cells = $urandom_range(1, side * side - 1);
      end
      pick = $urandom_range(5);
      density = (pick == 0) ? 0 : (pick == 1) ? 100 : $urandom_range(10, 90);
      for (int i = 0; i < cells; i++) begin
        b = ($urandom_range(99) < density);
        offer_cell(b, 1'b0, '0);
      end
      small_cells += cells;
    end

    drain();
    $display("Run summary: %0d cells sent over %0d grid_size writes, %0d result beats checked.",
             cells_sent, size_writes, tallies_seen);
    $display("Input pushed back on %0d cycles; sizes ran from one cell up to 64 columns.",
             stall_seen);
    if (errors == 0) begin
      $display("binary_grid_neighbor_count_3x3_test passed");
    end else begin
      $display("binary_grid_neighbor_count_3x3_test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bnc_pkg.sv
rtl/bnc_front.sv
rtl/bnc_queue.sv
rtl/bnc_back.sv
rtl/binary_grid_neighbor_count_3x3.sv
bench/binary_grid_neighbor_count_3x3_test.sv
